// ===== design/csv_line_field_splitter_macros.svh =====
// Assertion macros shared by the CSV field splitter modules.
// Each macro expects clk and rst to be visible where it is used.
`ifndef CSV_LINE_FIELD_SPLITTER_MACROS_SVH
`define CSV_LINE_FIELD_SPLITTER_MACROS_SVH

// Property holds at every clock edge outside reset.
`define CSVS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CSVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/csvs_pkg.sv =====
// Shared types, character codes and result-building helpers for the CSV splitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csvs_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [15:0] LINE_LIMIT_RESET = 16'd1024;
  localparam logic [15:0] LINE_LIMIT_MIN   = 16'd2;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       field_end;
    logic       line_end;
    logic       parse_error;
    logic       last;
  } res_t;

  // Up to two result beats produced by one input byte.
  typedef struct packed {
    res_t [1:0] res;
    logic [1:0] n;
  } step_t;

  function automatic step_t emit_char(step_t s, logic [7:0] ch);
    step_t r;
    r = s;
    r.res[s.n[0]] = '0;
    r.res[s.n[0]].out_char = ch;
    r.res[s.n[0]].char_valid = 1'b1;
    r.n = s.n + 2'd1;
    return r;
  endfunction

  function automatic step_t add_marks(step_t s, logic fe, logic le, logic err);
    step_t r;
    logic [1:0] idx;
    r = s;
    if (s.n == 2'd0) begin
      r.res[0] = '0;
      r.n = 2'd1;
    end
    idx = r.n - 2'd1;
    r.res[idx[0]].field_end   = r.res[idx[0]].field_end | fe;
    r.res[idx[0]].line_end    = r.res[idx[0]].line_end | le;
    r.res[idx[0]].parse_error = r.res[idx[0]].parse_error | err;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/csv_line_field_splitter.sv =====
// Channel   Dir  Handshake          Payload
// in        in   in_valid/in_stall  in_byte
// out       out  out_valid/out_stall out_char char_valid field_end line_end parse_error last
// cfg       in   cfg_wen            cfg_wdata (line_limit)
// One byte accepted per cycle unless stalled; each yields 0 to 2 registered result beats.
// Beats drain one per cycle unless out_stall, via a four-beat queue; in_stall rises when
// the queue holds three or more beats. rst is synchronous and clears parse state,
// the queue and line_limit (to 1024). out_stall only backs up the queue.
// Top level of the CSV field splitter; depends on csvs_pkg, csvs_step, csvs_result_fifo.
`timescale 1ns / 1ps
`default_nettype none

module csv_line_field_splitter
  import csvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic             field_end,
  output logic             line_end,
  output logic             parse_error,
  output logic             last
);

  logic  accept, full, empty, pop;
  step_t step;
  res_t  head;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = full;
  assign out_valid = !empty;
  assign pop       = out_valid && !out_stall;

  csvs_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_byte   (in_byte),
    .step      (step)
  );

  csvs_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .step  (step),
    .pop   (pop),
    .full  (full),
    .empty (empty),
    .head  (head)
  );

  assign out_char    = head.out_char;
  assign char_valid  = head.char_valid;
  assign field_end   = head.field_end;
  assign line_end    = head.line_end;
  assign parse_error = head.parse_error;
  assign last        = head.last;

endmodule

`default_nettype wire

// ===== design/csvs_step.sv =====
// Per-byte parse state, line limit register and result generation.
// Depends on csvs_pkg and csv_line_field_splitter_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "csv_line_field_splitter_macros.svh"

module csvs_step
  import csvs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  output step_t            step
);

  logic [15:0] line_limit;
  logic        field_open, quoted_mode, quote_seen, pending_quote, skip_rest;
  logic [15:0] line_count;

  logic        field_open_next, quoted_mode_next, quote_seen_next;
  logic        pending_quote_next, skip_rest_next;
  logic [15:0] line_count_next;

  logic [15:0] limit;
  logic [16:0] cnt;
  logic        hit, term;
  logic [1:0]  tail;
  step_t       s;

  always_comb begin
    limit = (line_limit < LINE_LIMIT_MIN) ? LINE_LIMIT_MIN : line_limit;
    cnt   = {1'b0, line_count} + 17'd1;
    hit   = cnt >= ({1'b0, limit} - 17'd1);
    term  = (in_byte == CH_NL) || (in_byte == CH_NUL);

    s = '0;
    field_open_next    = field_open;
    quoted_mode_next   = quoted_mode;
    quote_seen_next    = quote_seen;
    pending_quote_next = pending_quote;
    skip_rest_next     = skip_rest;
    line_count_next    = line_count;

    if (skip_rest) begin
      if (term || hit) begin
        s = add_marks(s, 1'b0, 1'b1, 1'b1);
        field_open_next    = 1'b0;
        quoted_mode_next   = 1'b0;
        quote_seen_next    = 1'b0;
        pending_quote_next = 1'b0;
        skip_rest_next     = 1'b0;
        line_count_next    = '0;
      end else begin
        line_count_next = cnt[15:0];
      end
    end else if (term) begin
      if (field_open) begin
        if (pending_quote) s = emit_char(s, CH_QUOTE);
        s = add_marks(s, 1'b1, 1'b1, 1'b0);
      end else begin
        s = add_marks(s, 1'b0, 1'b1, 1'b0);
      end
      field_open_next    = 1'b0;
      quoted_mode_next   = 1'b0;
      quote_seen_next    = 1'b0;
      pending_quote_next = 1'b0;
      skip_rest_next     = 1'b0;
      line_count_next    = '0;
    end else begin
      if (!field_open) begin
        if (in_byte == CH_COMMA) begin
          s = add_marks(s, 1'b1, 1'b0, 1'b0);
        end else if (in_byte == CH_QUOTE) begin
          field_open_next  = 1'b1;
          quoted_mode_next = 1'b1;
        end else begin
          field_open_next = 1'b1;
          s = emit_char(s, in_byte);
        end
      end else if (quoted_mode) begin
        if (quote_seen) begin
          quote_seen_next = 1'b0;
          if (in_byte == CH_QUOTE) begin
            s = emit_char(s, CH_QUOTE);
          end else if (in_byte == CH_COMMA) begin
            s = add_marks(s, 1'b1, 1'b0, 1'b0);
            field_open_next    = 1'b0;
            quoted_mode_next   = 1'b0;
            pending_quote_next = 1'b0;
          end else begin
            s = add_marks(s, 1'b1, 1'b0, 1'b1);
            field_open_next    = 1'b0;
            quoted_mode_next   = 1'b0;
            pending_quote_next = 1'b0;
            skip_rest_next     = 1'b1;
          end
        end else if (in_byte == CH_QUOTE) begin
          quote_seen_next = 1'b1;
        end else begin
          s = emit_char(s, in_byte);
        end
      end else begin
        if (in_byte == CH_COMMA) begin
          if (pending_quote) s = emit_char(s, CH_QUOTE);
          s = add_marks(s, 1'b1, 1'b0, 1'b0);
          field_open_next    = 1'b0;
          quoted_mode_next   = 1'b0;
          quote_seen_next    = 1'b0;
          pending_quote_next = 1'b0;
        end else if (in_byte == CH_QUOTE) begin
          if (pending_quote) begin
            s = emit_char(s, CH_QUOTE);
            pending_quote_next = 1'b0;
          end else begin
            pending_quote_next = 1'b1;
          end
        end else begin
          if (pending_quote) begin
            s = emit_char(s, CH_QUOTE);
            pending_quote_next = 1'b0;
          end
          s = emit_char(s, in_byte);
        end
      end

      // line limit reached: close the line with the updated field state
      if (hit) begin
        if (skip_rest_next) begin
          s = add_marks(s, 1'b0, 1'b1, 1'b1);
        end else if (field_open_next) begin
          if (pending_quote_next) s = emit_char(s, CH_QUOTE);
          s = add_marks(s, 1'b1, 1'b1, 1'b0);
        end else begin
          s = add_marks(s, 1'b0, 1'b1, 1'b0);
        end
        field_open_next    = 1'b0;
        quoted_mode_next   = 1'b0;
        quote_seen_next    = 1'b0;
        pending_quote_next = 1'b0;
        skip_rest_next     = 1'b0;
        line_count_next    = '0;
      end else begin
        line_count_next = cnt[15:0];
      end
    end

    tail = s.n - 2'd1;
    if (s.n != 2'd0) s.res[tail[0]].last = 1'b1;
    step = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit    <= LINE_LIMIT_RESET;
      field_open    <= 1'b0;
      quoted_mode   <= 1'b0;
      quote_seen    <= 1'b0;
      pending_quote <= 1'b0;
      skip_rest     <= 1'b0;
      line_count    <= '0;
    end else begin
      if (cfg_wen) line_limit <= cfg_wdata;
      if (accept) begin
        field_open    <= field_open_next;
        quoted_mode   <= quoted_mode_next;
        quote_seen    <= quote_seen_next;
        pending_quote <= pending_quote_next;
        skip_rest     <= skip_rest_next;
        line_count    <= line_count_next;
      end
    end
  end

  `CSVS_ASSERT(a_pair_layout, !(accept && step.n == 2'd2) || (step.res[0].char_valid && !step.res[0].last && step.res[1].last), "two-beat step with bad layout")
  `CSVS_ASSERT(a_quote_state, !(quote_seen && !quoted_mode) && !(pending_quote && quoted_mode), "quote flags inconsistent with field mode")
  `CSVS_ASSERT(a_skip_clean, !skip_rest || !field_open, "field open while dropping the rest of a line")

endmodule

`default_nettype wire

// ===== design/csvs_result_fifo.sv =====
// Four-beat result queue: takes up to two beats per cycle, issues one when popped.
// Depends on csvs_pkg and csv_line_field_splitter_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "csv_line_field_splitter_macros.svh"

module csvs_result_fifo
  import csvs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire step_t step,
  input  wire logic  pop,
  output logic       full,
  output logic       empty,
  output res_t       head
);

  res_t       mem [4];
  logic [1:0] wr_ptr, rd_ptr, wr_ptr_b;
  logic [2:0] count;
  logic [1:0] push_n;

  assign push_n   = push ? step.n : 2'd0;
  assign wr_ptr_b = wr_ptr + 2'd1;
  assign full     = count > 3'd2;
  assign empty    = count == 3'd0;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr] <= step.res[0];
    if (push_n == 2'd2) mem[wr_ptr_b] <= step.res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push_n} - {2'b00, pop};
    end
  end

  `CSVS_ASSERT(a_no_overflow, ({1'b0, count} + {2'b00, push_n}) <= 4'd4, "result queue overflow")
  `CSVS_ASSERT(a_no_underflow, !pop || !empty, "pop from empty result queue")
  `CSVS_ASSERT_NEXT(a_drain, count == 3'd1 && pop && push_n == 2'd0, empty, "queue not empty after last beat left")

endmodule

`default_nettype wire
